### rtl/core/mfr_pkg.sv
// shared constants and types for the rgb median filter core
// no dependencies; imported by every module of the core but mfr_ram
package mfr_pkg;

   localparam int SAMPLE_W     = 12;
   localparam int NUM_CH       = 3;
   localparam int PIX_W        = SAMPLE_W * NUM_CH;
   localparam int Y_W          = 12;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 12;
   localparam int CSR_DATA_W   = 12;
   localparam int CSR_ADDR_W   = 1;
   localparam int FIFO_DEPTH   = 8;
   localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

   typedef struct packed {
      logic med;
      logic border;
   } mfr_emit_type;

endpackage

### rtl/core/mfr_ram.sv
// generic single-write, single-read ram with registered read data
// depends on nothing
module mfr_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/core/mfr_median_lane.sv
// one channel lane: median of N samples by rank counting, two register stages
// depends on mfr_pkg
module mfr_median_lane
   import mfr_pkg::*;
#(
   parameter int N = 9
) (
   input  logic                           clock,
   input  logic [N-1:0][SAMPLE_W-1:0]     samples,
   output logic [SAMPLE_W-1:0]            median
);
   logic [N-1:0][N-1:0]          lt_in;
   logic [N-1:0][N-1:0]          lt_ff;
   logic [N-1:0][SAMPLE_W-1:0]   val_ff;
   logic [SAMPLE_W-1:0]          median_in;
   logic [SAMPLE_W-1:0]          median_ff;

   // lt_in[i][j]: sample j sorts ahead of sample i (ties broken by index)
   always_comb begin
      for (int i = 0; i < N; i++) begin
         for (int j = 0; j < N; j++) begin
            if (j < i) begin
               lt_in[i][j] = samples[j] <= samples[i];
            end else begin
               lt_in[i][j] = samples[j] < samples[i];
            end
         end
      end
   end

   always_comb begin
      median_in = '0;
      for (int i = 0; i < N; i++) begin
         if ($countones(lt_ff[i]) == N / 2) begin
            median_in = val_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      lt_ff     <= lt_in;
      val_ff    <= samples;
      median_ff <= median_in;
   end

   assign median = median_ff;
endmodule

### rtl/core/mfr_merge.sv
// merge stage: joins lane medians with coordinates, queues per-pixel records
// and splits each record into one or two result beats; depends on mfr_pkg
module mfr_merge
   import mfr_pkg::*;
#(
   parameter int XW = 10,
   parameter int RSP_W = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  mfr_emit_type          in_emit,
   input  logic [XW-1:0]         in_med_x,
   input  logic [Y_W-1:0]        in_med_y,
   input  logic [PIX_W-1:0]      in_med,
   input  logic [XW-1:0]         in_x,
   input  logic [Y_W-1:0]        in_y,
   input  logic [PIX_W-1:0]      in_pix,
   output logic [FIFO_CNT_W-1:0] count,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,  // x, y, red, green, blue
   output logic                  rsp_tlast
);
   localparam int PW = $clog2(FIFO_DEPTH);

   typedef struct packed {
      mfr_emit_type       emit;
      logic [XW-1:0]      med_x;
      logic [Y_W-1:0]     med_y;
      logic [PIX_W-1:0]   med;
      logic [XW-1:0]      x;
      logic [Y_W-1:0]     y;
      logic [PIX_W-1:0]   pix;
   } entry_type;

   entry_type               fifo_ff [FIFO_DEPTH];
   logic [PW-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    phase_ff, phase_in;
   entry_type               head;
   logic                    push, pop, beat, send_med;

   assign head     = fifo_ff[rd_ptr_ff];
   assign push     = in_valid && (in_emit.med || in_emit.border);
   assign send_med = head.emit.med && !phase_ff;
   assign beat     = rsp_tvalid && rsp_tready;
   assign pop      = beat && !(send_med && head.emit.border);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      phase_in  = phase_ff;
      if (beat) begin
         phase_in = !pop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         phase_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         phase_ff  <= phase_in;
      end
      if (push) begin
         fifo_ff[wr_ptr_ff] <= '{emit: in_emit, med_x: in_med_x, med_y: in_med_y,
                                 med: in_med, x: in_x, y: in_y, pix: in_pix};
      end
   end

   assign count      = count_ff;
   assign rsp_tvalid = count_ff != '0;
   assign rsp_tlast  = !(send_med && head.emit.border);
   assign rsp_tdata  = send_med ? RSP_W'({head.med, head.med_y, head.med_x})
                                : RSP_W'({head.pix, head.y, head.x});
endmodule

### rtl/core/median_filter_rgb_core.sv
// rgb median filter core: per-channel square-window median over a raster stream
// path: a pixel beat goes through s1 to s4 and the result queue before it shows on rsp
// throughput: one pixel beat per cycle while req_tready; a pixel with two results takes two rsp beats
// reset: synchronous, clears position, handshake and queue state; registers go to
// width 1024, height 768; line stores and window hold garbage until written
module median_filter_rgb_core
   import mfr_pkg::*;
#(
   parameter int WINDOW    = 3,
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   // pixel input
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [39:0]                  req_tdata,  // red, green, blue, zero pad
   input  logic                         req_tuser,  // frame_start
   // result output
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [((($clog2(MAX_WIDTH) + 48) + 7) / 8) * 8 - 1:0] rsp_tdata,
                                                    // pixel_x, pixel_y, red, green, blue, pad
   output logic                         rsp_tlast,  // last
   // register writes
   input  logic                         csr_we,
   input  logic [CSR_ADDR_W-1:0]        csr_addr,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);
   // kernel is the window forced odd
   localparam int KS    = (WINDOW - 1) | 1;
   localparam int RAD   = KS / 2;
   localparam int NTAP  = KS * KS;
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int RSP_W = (((XW + 48) + 7) / 8) * 8;

   typedef struct packed {
      logic               valid;
      mfr_emit_type       emit;
      logic [XW-1:0]      x;
      logic [Y_W-1:0]     y;
      logic [PIX_W-1:0]   pix;
   } tag_type;

   // config registers
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [WW-1:0]           w_eff;

   // raster position
   logic [XW-1:0]   column_ff, column_in;
   logic [Y_W-1:0]  row_ff, row_in;
   logic [XW-1:0]   cx;
   logic [Y_W-1:0]  cy;
   logic [XW:0]     nx;
   logic            drop, accept, take;
   mfr_emit_type    emit;

   // pipeline tags: s1 reads the line stores, s2 holds the window, s3/s4 follow the lanes
   tag_type          s1_ff, s2_ff, s3_ff, s4_ff;
   logic             byp_ff;
   logic [PIX_W-1:0] pix;
   logic [KS-1:0][PIX_W-1:0] new_col;
   logic [PIX_W-1:0] win_ff [KS][KS];

   logic [NUM_CH-1:0][NTAP-1:0][SAMPLE_W-1:0] lane_in;
   logic [NUM_CH-1:0][SAMPLE_W-1:0]           lane_med;
   logic [FIFO_CNT_W-1:0]                     fifo_count;
   logic [FIFO_CNT_W:0]                       occupancy;

   assign pix = req_tdata[PIX_W-1:0];

   // clamp the width into 1..MAX_WIDTH
   always_comb begin
      if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else if (width_ff == '0) begin
         w_eff = WW'(1);
      end else begin
         w_eff = WW'(width_ff);
      end
   end

   // position of the arriving pixel and the one after it
   always_comb begin
      cx = req_tuser ? '0 : column_ff;
      cy = req_tuser ? '0 : row_ff;
      if (cx >= w_eff) begin
         cx = '0;
         if (cy < height_ff) begin
            cy = cy + 1'b1;
         end
      end
      drop = cy >= height_ff;
      nx   = {1'b0, cx} + 1'b1;
      if (drop) begin
         column_in = cx;
         row_in    = cy;
      end else if (nx >= w_eff) begin
         column_in = '0;
         row_in    = cy + 1'b1;
      end else begin
         column_in = nx[XW-1:0];
         row_in    = cy;
      end
      emit.med    = (32'(cx) >= 2 * RAD) && (32'(cy) >= 2 * RAD);
      emit.border = (32'(cx) < RAD) || (32'(cy) < RAD)
                    || (32'(cx) + RAD >= 32'(w_eff)) || (32'(cy) + RAD >= 32'(height_ff));
   end

   // leave room in the queue for every pixel in flight
   assign occupancy  = (FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(s1_ff.valid)
                       + (FIFO_CNT_W + 1)'(s2_ff.valid) + (FIFO_CNT_W + 1)'(s3_ff.valid)
                       + (FIFO_CNT_W + 1)'(s4_ff.valid);
   assign req_tready = occupancy < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
   assign accept     = req_tvalid && req_tready;
   assign take       = accept && !drop;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_REG_W'(1024);
         height_ff <= HEIGHT_REG_W'(768);
         column_ff <= '0;
         row_ff    <= '0;
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_REG_W-1:0];
               REG_IMAGE_HEIGHT: height_ff <= csr_wdata[HEIGHT_REG_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            column_ff <= column_in;
            row_ff    <= row_in;
         end
         s1_ff.valid <= take;
         s2_ff.valid <= s1_ff.valid;
         s3_ff.valid <= s2_ff.valid;
         s4_ff.valid <= s3_ff.valid;
      end
      // payload side of the tags
      s1_ff.emit <= emit;
      s1_ff.x    <= cx;
      s1_ff.y    <= cy;
      s1_ff.pix  <= pix;
      // same column as the pixel now writing back: ram read would be stale
      byp_ff     <= s1_ff.valid && (s1_ff.x == cx);
      {s2_ff.emit, s2_ff.x, s2_ff.y, s2_ff.pix} <= {s1_ff.emit, s1_ff.x, s1_ff.y, s1_ff.pix};
      {s3_ff.emit, s3_ff.x, s3_ff.y, s3_ff.pix} <= {s2_ff.emit, s2_ff.x, s2_ff.y, s2_ff.pix};
      {s4_ff.emit, s4_ff.x, s4_ff.y, s4_ff.pix} <= {s3_ff.emit, s3_ff.x, s3_ff.y, s3_ff.pix};
   end

   // line stores: row k holds the pixel k+1 rows above, read in s0, written back in s1
   generate
      if (KS > 1) begin : g_lines
         logic [KS-2:0][PIX_W-1:0] ram_q;
         logic [KS-2:0][PIX_W-1:0] ls_rd;
         logic [KS-2:0][PIX_W-1:0] ls_wr;
         logic [KS-2:0][PIX_W-1:0] ls_wr_ff;

         for (genvar k = 0; k < KS - 1; k++) begin : g_row
            mfr_ram #(
               .WIDTH (PIX_W),
               .DEPTH (MAX_WIDTH)
            ) u_line (
               .clock   (clock),
               .wr_en   (s1_ff.valid),
               .wr_addr (s1_ff.x),
               .wr_data (ls_wr[k]),
               .rd_en   (take),
               .rd_addr (cx),
               .rd_data (ram_q[k])
            );
            assign ls_rd[k] = byp_ff ? ls_wr_ff[k] : ram_q[k];
            if (k == 0) begin : g_first
               assign ls_wr[k] = s1_ff.pix;
            end else begin : g_next
               assign ls_wr[k] = ls_rd[k-1];
            end
            assign new_col[KS-2-k] = ls_rd[k];
         end

         always_ff @(posedge clock) begin
            ls_wr_ff <= ls_wr;
         end
      end
   endgenerate

   assign new_col[KS-1] = s1_ff.pix;

   // window: shift left one column, new column enters on the right
   always_ff @(posedge clock) begin
      if (s1_ff.valid) begin
         for (int r = 0; r < KS; r++) begin
            for (int c = 0; c < KS - 1; c++) begin
               win_ff[r][c] <= win_ff[r][c+1];
            end
            win_ff[r][KS-1] <= new_col[r];
         end
      end
   end

   // one lane per color channel
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         for (int r = 0; r < KS; r++) begin
            for (int c = 0; c < KS; c++) begin
               lane_in[ch][r*KS+c] = win_ff[r][c][ch*SAMPLE_W +: SAMPLE_W];
            end
         end
      end
   end

   generate
      for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
         mfr_median_lane #(
            .N (NTAP)
         ) u_lane (
            .clock   (clock),
            .samples (lane_in[ch]),
            .median  (lane_med[ch])
         );
      end
   endgenerate

   // median of a window belongs to the centre, RAD up and left of the newest pixel
   mfr_merge #(
      .XW    (XW),
      .RSP_W (RSP_W)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s4_ff.valid),
      .in_emit    (s4_ff.emit),
      .in_med_x   (s4_ff.x - XW'(RAD)),
      .in_med_y   (s4_ff.y - Y_W'(RAD)),
      .in_med     ({lane_med[2], lane_med[1], lane_med[0]}),
      .in_x       (s4_ff.x),
      .in_y       (s4_ff.y),
      .in_pix     (s4_ff.pix),
      .count      (fifo_count),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule

### rtl/core/mfr_checker.sv
// port-level checks for the rgb median filter core, with the bind that attaches them
// depends on mfr_pkg and median_filter_rgb_core
module mfr_checker
   import mfr_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [((($clog2(MAX_WIDTH) + 48) + 7) / 8) * 8 - 1:0] rsp_tdata,
   input logic                         rsp_tlast
);
   localparam int XW = $clog2(MAX_WIDTH);

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   // second beat of a pixel comes from the same record, still at the head of the queue
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("second beat of a pair missing");

   // row never reaches the largest code
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[XW+Y_W-1:XW] != {Y_W{1'b1}})
      else $error("row out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled beat changed");
endmodule

bind median_filter_rgb_core mfr_checker #(.MAX_WIDTH(MAX_WIDTH)) u_mfr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

### bench/tb_median_filter_rgb_core.sv
// testbench for median_filter_rgb_core: directed and random frames checked
// against an internal per-channel 3x3 median predictor; depends on mfr_pkg and the core
`timescale 1ns / 100ps

module tb_median_filter_rgb_core
   import mfr_pkg::*;
;

   localparam int IMG_MAX_W = 1024;
   localparam int TAIL_CYCLES = 20;  // comfortably past the time a result takes to leave the core pipeline

   // one emitted result beat as the predictor sees it
   typedef struct {
      logic [9:0]  px;
      logic [11:0] py;
      logic [11:0] red;
      logic [11:0] green;
      logic [11:0] blue;
      logic        last;
   } filtered_pixel_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   median_filter_rgb_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // red, green, blue, zero pad
      .req_tuser  (req_tuser),   // frame_start
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // pixel_x, pixel_y, red, green, blue, pad
      .rsp_tlast  (rsp_tlast),   // last
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // predictor state: two previous rows, 3x3 window, position and registers
   logic [PIX_W-1:0] row_hist [2][IMG_MAX_W];
   logic [PIX_W-1:0] win [3][3];
   int unsigned col_pos, row_pos;
   int unsigned width_reg, height_reg;

   filtered_pixel_type pending_q [$];
   int unsigned mismatch_count;
   int unsigned send_idle_pct, recv_idle_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // median of one channel over the current window
   function automatic logic [11:0] window_median(int sh);
      logic [11:0] v [9];
      logic [11:0] t;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            v[i*3+j] = win[i][j][sh +: 12];
      for (int i = 0; i < 9; i++)
         for (int j = 0; j < 8 - i; j++)
            if (v[j] > v[j+1]) begin
               t = v[j]; v[j] = v[j+1]; v[j+1] = t;
            end
      return v[4];
   endfunction

   // advance the predictor by one accepted pixel beat and queue its results
   task automatic predict_pixel(input logic [11:0] r, g, b, input logic fs);
      logic [PIX_W-1:0] pix;
      int unsigned w, x, y;
      logic is_border, is_centre;
      filtered_pixel_type res;
      pix = {b, g, r};
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      w = width_reg;
      if (w < 1) w = 1;
      if (w > IMG_MAX_W) w = IMG_MAX_W;
      x = col_pos;
      y = row_pos;
      // width lowered under a running row: wrap first
      if (x >= w) begin
         x = 0;
         if (y < height_reg) y++;
      end
      col_pos = x;
      row_pos = y;
      // past the last row: dropped, position holds
      if (y >= height_reg) return;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[2][2] = pix;
      win[1][2] = row_hist[0][x];
      win[0][2] = row_hist[1][x];
      row_hist[1][x] = row_hist[0][x];
      row_hist[0][x] = pix;
      is_centre = (x >= 2) && (y >= 2);
      is_border = (x < 1) || (y < 1) || (x + 1 >= w) || (y + 1 >= height_reg);
      // completed interior centre goes out ahead of the border pixel
      if (is_centre) begin
         res.px = 10'(x - 1);
         res.py = 12'(y - 1);
         res.red = window_median(0);
         res.green = window_median(12);
         res.blue = window_median(24);
         res.last = !is_border;
         pending_q.push_back(res);
      end
      if (is_border) begin
         res.px = 10'(x);
         res.py = 12'(y);
         res.red = r;
         res.green = g;
         res.blue = b;
         res.last = 1'b1;
         pending_q.push_back(res);
      end
      x++;
      if (x >= w) begin
         x = 0;
         y++;
      end
      col_pos = x;
      row_pos = y;
   endtask

   // result side: random stalls and in-order field compare
   always @(posedge clock) begin
      filtered_pixel_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_q.size() == 0) begin
               $display("%0t: unexpected beat, actual %h last %b", $time, rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               e = pending_q.pop_front();
               if (rsp_tdata[9:0] !== e.px || rsp_tdata[21:10] !== e.py
                   || rsp_tdata[33:22] !== e.red || rsp_tdata[45:34] !== e.green
                   || rsp_tdata[57:46] !== e.blue || rsp_tlast !== e.last) begin
                  $display("%0t: expected x %0d y %0d rgb %h %h %h last %b", $time,
                           e.px, e.py, e.red, e.green, e.blue, e.last);
                  $display("%0t: actual   x %0d y %0d rgb %h %h %h last %b", $time,
                           rsp_tdata[9:0], rsp_tdata[21:10], rsp_tdata[33:22],
                           rsp_tdata[45:34], rsp_tdata[57:46], rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // send one pixel beat; valid stays high afterwards so back-to-back beats need no gap
   task automatic send_pixel(input logic [11:0] r, g, b, input logic fs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, b, g, r};
      req_tuser <= fs;
      do @(posedge clock); while (!req_tready);
      predict_pixel(r, g, b, fs);
   endtask

   // stop sending and let every expected beat arrive
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_IMAGE_WIDTH) width_reg = val & 11'h7ff;
      else height_reg = val & 12'hfff;
   endtask

   task automatic set_frame_size(input int unsigned w, h);
      drain_results();
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
   endtask

   function automatic logic [11:0] rand_sample();
      case ($urandom_range(7))
         0: return 12'd0;
         1: return 12'hfff;
         default: return 12'($urandom);
      endcase
   endfunction

   // reset-time registers: a short first row at width 1024, height 768
   task automatic test_reset_defaults();
      for (int i = 0; i < 6; i++)
         send_pixel(rand_sample(), rand_sample(), rand_sample(), i == 0);
   endtask

   // 4x4 frame of extremes: single and double result beats, then drops past the last row
   task automatic test_small_frame();
      logic [11:0] lo_hi;
      set_frame_size(4, 4);
      for (int i = 0; i < 19; i++) begin
         lo_hi = (i % 3 == 0) ? 12'hfff : 12'd0;
         send_pixel(lo_hi, ~lo_hi, (i % 2) ? 12'hfff : 12'd0, i == 0);
      end
   endtask

   // width 0 acts as 1, width above the line store clamps to 1024
   task automatic test_width_limits();
      set_frame_size(0, 3);
      for (int i = 0; i < 5; i++)
         send_pixel(rand_sample(), rand_sample(), rand_sample(), i == 0);
      set_frame_size(2047, 2);
      for (int i = 0; i < 1026; i++)
         send_pixel(rand_sample(), rand_sample(), rand_sample(), i == 0);
   endtask

   // height 0 drops everything; largest height with a short frame
   task automatic test_height_limits();
      set_frame_size(3, 0);
      for (int i = 0; i < 4; i++)
         send_pixel(rand_sample(), rand_sample(), rand_sample(), i == 0);
      set_frame_size(5, 4095);
      for (int i = 0; i < 18; i++)
         send_pixel(rand_sample(), rand_sample(), rand_sample(), i == 0);
   endtask

   // width lowered while a row is half done: the next beat wraps to a new row
   task automatic test_width_lowered();
      set_frame_size(8, 6);
      for (int i = 0; i < 13; i++)
         send_pixel(rand_sample(), rand_sample(), rand_sample(), i == 0);
      drain_results();
      write_reg(REG_IMAGE_WIDTH, 3);
      for (int i = 0; i < 10; i++)
         send_pixel(rand_sample(), rand_sample(), rand_sample(), 1'b0);
   endtask

   // random frame sizes and content, some frames cut short or overrun
   task automatic test_random_frames(input int unsigned s_pct, r_pct, n_items);
      int unsigned sent, w, h, frames, len;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      sent = 0;
      while (sent < n_items) begin
         w = ($urandom_range(4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
         h = ($urandom_range(4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
         set_frame_size(w, h);
         frames = $urandom_range(1, 3);
         for (int f = 0; f < frames && sent < n_items; f++) begin
            len = w * h;
            case ($urandom_range(9))
               0: len = $urandom_range(1, len);        // broken frame
               1: len = len + $urandom_range(1, 4);    // overrun, extra beats dropped
               default: ;
            endcase
            // the beat budget may also cut a frame short
            for (int i = 0; i < len && sent < n_items; i++) begin
               send_pixel(rand_sample(), rand_sample(), rand_sample(), i == 0);
               sent++;
            end
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      mismatch_count = 0;
      send_idle_pct = 7;
      recv_idle_pct = 84;
      col_pos = 0;
      row_pos = 0;
      width_reg = 1024;
      height_reg = 768;
      pending_q.delete();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_small_frame();
      test_width_limits();
      test_height_limits();
      test_width_lowered();
      test_random_frames(7, 84, 16);
      test_random_frames(84, 7, 16);
      test_random_frames(0, 0, 17);
      drain_results();

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/mfr_pkg.sv
rtl/core/mfr_ram.sv
rtl/core/mfr_median_lane.sv
rtl/core/mfr_merge.sv
rtl/core/median_filter_rgb_core.sv
rtl/core/mfr_checker.sv
bench/tb_median_filter_rgb_core.sv
